### hdl/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// CSV field splitter package
// Character codes, parser modes, command codes and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package csvfs_pkg;

   // character codes
   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] COMMA_CHAR = 8'h2C;
   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] TAB_CHAR   = 8'h09;
   localparam logic [7:0] CR_CHAR    = 8'h0D;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // parser modes, one-hot
   typedef enum logic [5:0] {
      MODE_START  = 6'b000001,
      MODE_PLAIN  = 6'b000010,
      MODE_QUOTED = 6'b000100,
      MODE_QSEEN  = 6'b001000,
      MODE_SKIP   = 6'b010000,
      MODE_DEAD   = 6'b100000
   } mode_type;

   // back end actions
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,   // nothing but a possible line end
      OP_EMIT  = 2'd1,   // one result beat
      OP_HOLD  = 2'd2,   // store a trailing space
      OP_FLUSH = 2'd3    // held spaces, then one byte beat
   } op_type;

   // command word, less the held-space count/index which is sized per instance
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       valid;
      logic       fend;
      logic       ovf;
      logic       eol;
      logic       lhb;    // line had bytes: field_end on the line-end beat
   } cmd_core_type;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
   endfunction

endpackage

### hdl/csvfs_if.sv
// ----------------------------------------------------------------------------
// CSV field splitter channels
// Valid/ready channels for line bytes in and field beats out.
// ----------------------------------------------------------------------------
interface csvfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       line_last;   // line ends after this beat

   modport source (output valid, data_byte, has_byte, line_last, input ready);
   modport sink   (input valid, data_byte, has_byte, line_last, output ready);
endinterface

interface csvfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic       line_end;
   logic       space_overflow;
   logic       last_of_run;

   modport source (output valid, out_byte, byte_valid, field_end, line_end,
                   space_overflow, last_of_run, input ready);
   modport sink   (input valid, out_byte, byte_valid, field_end, line_end,
                   space_overflow, last_of_run, output ready);
endinterface

### hdl/csv_line_field_splitter_top.sv
// ----------------------------------------------------------------------------
// CSV line field splitter
// Splits a CSV line, one byte per beat, into field bytes and field/line ends.
//
//   Channel   Dir  Handshake     Beat contents
//   req_bus   in   valid/ready   data_byte, has_byte, line_last
//   rsp_bus   out  valid/ready   out_byte, byte_valid, field_end, line_end,
//                                space_overflow, last_of_run
//
// The front end takes one beat a cycle while the command queue has room.
// The back end pops a command in its idle state, then sends its result beats;
// each held space flushed is fetched by a registered read of the held-space
// buffer before its beat is sent.
// Synchronous reset clears parser and sequencer state; no clearing pass.
// A stalled result channel fills the queue, then req_bus ready drops.
// ----------------------------------------------------------------------------
module csv_line_field_splitter_top #(
   parameter int MAX_HELD_SPACES = 16
) (
   input  logic        clock,
   input  logic        reset,
   csvfs_req_if.sink   req_bus,
   csvfs_rsp_if.source rsp_bus
);

   localparam int CntW  = $clog2(MAX_HELD_SPACES + 1);
   localparam int CmdW  = $bits(csvfs_pkg::cmd_core_type) + CntW;

   csvfs_pkg::cmd_core_type push_cmd, pop_cmd;
   logic [CntW-1:0]         push_count, pop_count;
   logic [CmdW-1:0]         pop_word;
   logic                    q_push, q_pop, q_full, q_empty;

   csvfs_front #(.MAX_HELD_SPACES(MAX_HELD_SPACES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .q_full    (q_full),
      .q_push    (q_push),
      .cmd       (push_cmd),
      .cmd_count (push_count)
   );

   csvfs_queue #(.WIDTH(CmdW), .DEPTH(csvfs_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_cmd, push_count}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_word),
      .empty     (q_empty)
   );

   assign {pop_cmd, pop_count} = pop_word;

   csvfs_back #(.MAX_HELD_SPACES(MAX_HELD_SPACES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_cmd   (pop_cmd),
      .q_count (pop_count),
      .rsp     (rsp_bus)
   );

endmodule

### hdl/csvfs_front.sv
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Accepts line bytes, runs the parser state and issues one command per beat
// that needs any back end work.
// ----------------------------------------------------------------------------
module csvfs_front #(
   parameter int  MAX_HELD_SPACES = 16,
   localparam int CntW = $clog2(MAX_HELD_SPACES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   csvfs_req_if.sink             req,
   input  logic                  q_full,
   output logic                  q_push,
   output csvfs_pkg::cmd_core_type cmd,
   output logic [CntW-1:0]       cmd_count
);

   csvfs_pkg::mode_type mode_ff, mode_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                lhb_ff, lhb_in;
   logic                accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // parser step
   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      lhb_in    = lhb_ff;
      cmd.op    = csvfs_pkg::OP_NONE;
      cmd.data  = '0;
      cmd.valid = 1'b0;
      cmd.fend  = 1'b0;
      cmd.ovf   = 1'b0;
      cmd.eol   = 1'b0;
      cmd.lhb   = 1'b0;
      cmd_count = '0;
      if (accept) begin
         if (req.has_byte && (mode_ff != csvfs_pkg::MODE_DEAD)) begin
            if (req.data_byte == csvfs_pkg::NUL_CHAR) begin
               // rest of line is ignored
               mode_in = csvfs_pkg::MODE_DEAD;
               cnt_in  = '0;
            end else begin
               lhb_in = 1'b1;
               unique case (mode_ff) inside
                  csvfs_pkg::MODE_PLAIN: begin
                     if (req.data_byte == csvfs_pkg::COMMA_CHAR) begin
                        cnt_in   = '0;
                        cmd.op   = csvfs_pkg::OP_EMIT;
                        cmd.fend = 1'b1;
                        mode_in  = csvfs_pkg::MODE_START;
                     end else if (csvfs_pkg::is_space(req.data_byte)) begin
                        if (cnt_ff < CntW'(MAX_HELD_SPACES)) begin
                           cmd.op    = csvfs_pkg::OP_HOLD;
                           cmd.data  = req.data_byte;
                           cmd_count = cnt_ff;
                           cnt_in    = cnt_ff + CntW'(1);
                        end else begin
                           cmd.op  = csvfs_pkg::OP_EMIT;
                           cmd.ovf = 1'b1;
                        end
                     end else begin
                        cmd.op    = csvfs_pkg::OP_FLUSH;
                        cmd.data  = req.data_byte;
                        cmd.valid = 1'b1;
                        cmd_count = cnt_ff;
                        cnt_in    = '0;
                     end
                  end
                  csvfs_pkg::MODE_QUOTED: begin
                     if (req.data_byte == csvfs_pkg::QUOTE_CHAR) begin
                        mode_in = csvfs_pkg::MODE_QSEEN;
                     end else begin
                        cmd.op    = csvfs_pkg::OP_EMIT;
                        cmd.data  = req.data_byte;
                        cmd.valid = 1'b1;
                     end
                  end
                  csvfs_pkg::MODE_QSEEN, csvfs_pkg::MODE_SKIP: begin
                     if ((mode_ff == csvfs_pkg::MODE_QSEEN) &&
                         (req.data_byte == csvfs_pkg::QUOTE_CHAR)) begin
                        // doubled quote
                        cmd.op    = csvfs_pkg::OP_EMIT;
                        cmd.data  = csvfs_pkg::QUOTE_CHAR;
                        cmd.valid = 1'b1;
                        mode_in   = csvfs_pkg::MODE_QUOTED;
                     end else if (req.data_byte == csvfs_pkg::COMMA_CHAR) begin
                        cmd.op   = csvfs_pkg::OP_EMIT;
                        cmd.fend = 1'b1;
                        mode_in  = csvfs_pkg::MODE_START;
                     end else begin
                        mode_in = csvfs_pkg::MODE_SKIP;
                     end
                  end
                  default: begin
                     // field start, and any stray code
                     if (csvfs_pkg::is_space(req.data_byte)) begin
                        mode_in = csvfs_pkg::MODE_START;
                     end else if (req.data_byte == csvfs_pkg::QUOTE_CHAR) begin
                        mode_in = csvfs_pkg::MODE_QUOTED;
                     end else if (req.data_byte == csvfs_pkg::COMMA_CHAR) begin
                        cmd.op   = csvfs_pkg::OP_EMIT;
                        cmd.fend = 1'b1;
                        mode_in  = csvfs_pkg::MODE_START;
                     end else begin
                        cnt_in    = '0;
                        cmd.op    = csvfs_pkg::OP_EMIT;
                        cmd.data  = req.data_byte;
                        cmd.valid = 1'b1;
                        mode_in   = csvfs_pkg::MODE_PLAIN;
                     end
                  end
               endcase
            end
         end
         // line end closes the last field and clears everything
         if (req.line_last) begin
            cmd.eol = 1'b1;
            cmd.lhb = lhb_in;
            mode_in = csvfs_pkg::MODE_START;
            cnt_in  = '0;
            lhb_in  = 1'b0;
         end
      end
      q_push = accept && ((cmd.op != csvfs_pkg::OP_NONE) || cmd.eol);
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csvfs_pkg::MODE_START;
         cnt_ff  <= '0;
         lhb_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         lhb_ff  <= lhb_in;
      end
   end

   // held count never passes the buffer size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MAX_HELD_SPACES))
      else $error("held space count beyond buffer size");

endmodule

### hdl/csvfs_queue.sv
// ----------------------------------------------------------------------------
// CSV field splitter command queue
// Small flip-flop FIFO between front and back end.
// ----------------------------------------------------------------------------
module csvfs_queue #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 4,
   localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LvlW  = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]  level_ff, level_in;

   assign full     = (level_ff == LvlW'(DEPTH));
   assign empty    = (level_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LvlW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LvlW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue popped while empty");

endmodule

### hdl/csvfs_back.sv
// ----------------------------------------------------------------------------
// CSV field splitter back end
// Runs queued commands: keeps the held-space buffer, flushes it and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module csvfs_back #(
   parameter int  MAX_HELD_SPACES = 16,
   localparam int CntW = $clog2(MAX_HELD_SPACES + 1),
   localparam int IdxW = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  csvfs_pkg::cmd_core_type q_cmd,
   input  logic [CntW-1:0]         q_count,
   csvfs_rsp_if.source             rsp
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_HELD  = 5'b00100,
      ST_MAIN  = 5'b01000,
      ST_LEND  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   csvfs_pkg::cmd_core_type cmd_ff, cmd_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [CntW-1:0]         idx_ff, idx_in;
   logic [CntW-1:0]         idx_next;

   logic [7:0]              held_mem [MAX_HELD_SPACES];
   logic [7:0]              held_rd_ff;
   logic                    mem_we;
   logic                    mem_re;

   logic                    slot_free;
   logic                    load;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   logic                    out_bvalid_ff, out_bvalid_in;
   logic                    out_fend_ff, out_fend_in;
   logic                    out_lend_ff, out_lend_in;
   logic                    out_ovf_ff, out_ovf_in;
   logic                    out_last_ff, out_last_in;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign idx_next  = idx_ff + CntW'(1);

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      load          = 1'b0;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_fend_in   = out_fend_ff;
      out_lend_in   = out_lend_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               cnt_in = q_count;
               idx_in = '0;
               case (q_cmd.op)
                  csvfs_pkg::OP_HOLD: begin
                     mem_we   = 1'b1;
                     state_in = q_cmd.eol ? ST_LEND : ST_IDLE;
                  end
                  csvfs_pkg::OP_FLUSH: begin
                     state_in = (q_count != '0) ? ST_FETCH : ST_MAIN;
                  end
                  csvfs_pkg::OP_EMIT: begin
                     state_in = ST_MAIN;
                  end
                  default: begin
                     state_in = ST_LEND;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            mem_re   = 1'b1;
            state_in = ST_HELD;
         end
         ST_HELD: begin
            if (slot_free) begin
               load          = 1'b1;
               out_byte_in   = held_rd_ff;
               out_bvalid_in = 1'b1;
               out_fend_in   = 1'b0;
               out_lend_in   = 1'b0;
               out_ovf_in    = 1'b0;
               out_last_in   = 1'b0;
               idx_in        = idx_next;
               state_in      = (idx_next < cnt_ff) ? ST_FETCH : ST_MAIN;
            end
         end
         ST_MAIN: begin
            if (slot_free) begin
               load          = 1'b1;
               out_byte_in   = cmd_ff.data;
               out_bvalid_in = cmd_ff.valid;
               out_fend_in   = cmd_ff.fend;
               out_lend_in   = 1'b0;
               out_ovf_in    = cmd_ff.ovf;
               out_last_in   = !cmd_ff.eol;
               state_in      = cmd_ff.eol ? ST_LEND : ST_IDLE;
            end
         end
         ST_LEND: begin
            if (slot_free) begin
               load          = 1'b1;
               out_byte_in   = '0;
               out_bvalid_in = 1'b0;
               out_fend_in   = cmd_ff.lhb;
               out_lend_in   = 1'b1;
               out_ovf_in    = 1'b0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_fend_ff   <= out_fend_in;
      out_lend_ff   <= out_lend_in;
      out_ovf_ff    <= out_ovf_in;
      out_last_ff   <= out_last_in;
   end

   // held-space buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[q_count[IdxW-1:0]] <= q_cmd.data;
      end
      if (mem_re) begin
         held_rd_ff <= held_mem[idx_ff[IdxW-1:0]];
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.out_byte       = out_byte_ff;
   assign rsp.byte_valid     = out_bvalid_ff;
   assign rsp.field_end      = out_fend_ff;
   assign rsp.line_end       = out_lend_ff;
   assign rsp.space_overflow = out_ovf_ff;
   assign rsp.last_of_run    = out_last_ff;

   // flush only reads entries that were stored for this field
   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (idx_ff < cnt_ff))
      else $error("held buffer read past stored count");

   // the line-end beat always closes its item's run
   a_lend_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.line_end) |-> rsp.last_of_run)
      else $error("line end beat without last_of_run");

endmodule
